>>> hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared widths, phase and event codes, and the queue entry and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  localparam int DeltaBits  = 28;
  localparam int TotalBits  = 32;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] SysexStart  = 8'hf0;
  localparam logic [7:0] SysexEscape = 8'hf7;
  localparam logic [7:0] MetaStatus  = 8'hff;
  localparam logic [7:0] MetaTempo   = 8'h51;
  localparam logic [7:0] MetaEot     = 8'h2f;
  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [7:0] ProgChange  = 8'hc0;
  localparam logic [7:0] ChanPress   = 8'hd0;
  localparam logic [7:0] HighNibble  = 8'hf0;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SKIPLEN, PH_SKIP,
    PH_METATYPE, PH_TEMPOLEN, PH_TEMPO1, PH_TEMPO2, PH_TEMPO3, PH_EOTLEN
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MIDI  = 3'd0,
    KIND_TEMPO = 3'd1,
    KIND_EOT   = 3'd2,
    KIND_END   = 3'd3,
    KIND_TRUNC = 3'd4
  } kind_t;

  typedef struct packed {
    logic        evt_valid;
    kind_t       evt_kind;
    logic [27:0] delta;
    logic [31:0] total;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [7:0]  meta_len;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  d3;
    logic        end_valid;
    logic        end_trunc;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [27:0] delta;
    logic [31:0] total;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [7:0]  meta_len;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  d3;
    logic        last;
  } result_t;

  function automatic logic [27:0] delta_field(input logic [DeltaBits-1:0] d);
    logic [31:0] wide;
    wide = 32'(d);
    return wide[27:0];
  endfunction

  function automatic logic one_data_byte(input logic [7:0] st);
    return ((st & HighNibble) == ProgChange) || ((st & HighNibble) == ChanPress);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses a standard MIDI track byte stream into midi, tempo, end-of-track,
// end-of-data and truncation result items.
// ----------------------------------------------------------------------------
// The block takes one track byte per cycle unless the queue is full. The front
// end parses every byte combinationally and writes an entry into a four-deep
// queue whenever the byte completes an event or ends the data; the back end
// turns each entry into result items through an output register. A byte causes
// at most two results (an event and the end-of-data item), each of which
// takes its own turn in the output register, so the sustained rate is one byte
// per cycle unless end bytes that also complete events come faster than the
// queue drains or the output is stalled. The first result of a byte passes
// through the queue and then the output register. The input stalls only while
// the queue is full.
`default_nettype none

module midi_track_event_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_kind,
  output logic [27:0]      out_tick_delta,
  output logic [31:0]      out_total_ticks,
  output logic [7:0]       out_status_byte,
  output logic [7:0]       out_meta_type,
  output logic [7:0]       out_meta_length,
  output logic [7:0]       out_first_data,
  output logic [7:0]       out_second_data,
  output logic [7:0]       out_third_data,
  output logic             out_last_of_run
);

  logic               accept;
  logic               push;
  logic               pop;
  logic               q_valid;
  logic               q_full;
  mtep_pkg::entry_t   push_entry;
  mtep_pkg::entry_t   q_head;
  mtep_pkg::result_t  res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mtep_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .end_of_data (in_end_of_data),
    .push        (push),
    .entry       (push_entry)
  );

  mtep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .not_empty  (q_valid),
    .full       (q_full),
    .head       (q_head)
  );

  mtep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_event_kind  = res.kind;
  assign out_tick_delta  = res.delta;
  assign out_total_ticks = res.total;
  assign out_status_byte = res.status;
  assign out_meta_type   = res.meta_type;
  assign out_meta_length = res.meta_len;
  assign out_first_data  = res.d1;
  assign out_second_data = res.d2;
  assign out_third_data  = res.d3;
  assign out_last_of_run = res.last;

endmodule

`default_nettype wire

>>> hw/rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Parses one track byte per accepted item; a byte that completes an event or ends
// the data writes a queue entry holding the event and any end-of-data result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_data,
  output logic                 push,
  output mtep_pkg::entry_t     entry
);

  localparam int DB = mtep_pkg::DeltaBits;

  mtep_pkg::phase_t    phase_r, phase_nxt;
  logic [DB-1:0]       acc_r, acc_nxt;
  logic [DB-1:0]       held_delta_r, held_delta_nxt;
  logic [31:0]         tick_r, tick_nxt;
  logic [7:0]          run_r, run_nxt;
  logic [7:0]          cur_r, cur_nxt;
  logic [7:0]          mtype_r, mtype_nxt;
  logic [7:0]          hd0_r, hd0_nxt;
  logic [7:0]          hd1_r, hd1_nxt;
  logic [7:0]          hd3_r, hd3_nxt;
  logic [DB-1:0]       skip_r, skip_nxt;
  logic [DB-1:0]       acc_push;
  logic [DB-1:0]       skip_dec;

  always_comb begin
    acc_push       = {acc_r[DB-8:0], data_byte[6:0]};
    skip_dec       = skip_r - DB'(1);
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    held_delta_nxt = held_delta_r;
    tick_nxt       = tick_r;
    run_nxt        = run_r;
    cur_nxt        = cur_r;
    mtype_nxt      = mtype_r;
    hd0_nxt        = hd0_r;
    hd1_nxt        = hd1_r;
    hd3_nxt        = hd3_r;
    skip_nxt       = skip_r;
    entry          = '0;
    entry.evt_kind = mtep_pkg::KIND_MIDI;

    unique case (phase_r)
      mtep_pkg::PH_DELTA: begin
        acc_nxt = acc_push;
        if (!data_byte[7]) begin
          held_delta_nxt = acc_push;
          tick_nxt       = tick_r + 32'(acc_push);
          acc_nxt        = '0;
          phase_nxt      = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (data_byte == mtep_pkg::SysexStart || data_byte == mtep_pkg::SysexEscape) begin
          acc_nxt   = '0;
          phase_nxt = mtep_pkg::PH_SKIPLEN;
        end else if (data_byte == mtep_pkg::MetaStatus) begin
          phase_nxt = mtep_pkg::PH_METATYPE;
        end else if ((data_byte & mtep_pkg::StatusBit) != 8'h00) begin
          cur_nxt   = data_byte;
          run_nxt   = data_byte;
          phase_nxt = mtep_pkg::PH_DATA1;
        end else begin
          cur_nxt = run_r;
          hd0_nxt = data_byte;
          if (mtep_pkg::one_data_byte(run_r)) begin
            entry.evt_valid = 1'b1;
            entry.status    = run_r;
            entry.d1        = data_byte;
            phase_nxt       = mtep_pkg::PH_DELTA;
          end else begin
            phase_nxt = mtep_pkg::PH_DATA2;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        hd0_nxt = data_byte;
        if (mtep_pkg::one_data_byte(cur_r)) begin
          entry.evt_valid = 1'b1;
          entry.status    = cur_r;
          entry.d1        = data_byte;
          phase_nxt       = mtep_pkg::PH_DELTA;
        end else begin
          phase_nxt = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        hd1_nxt         = data_byte;
        entry.evt_valid = 1'b1;
        entry.status    = cur_r;
        entry.d1        = hd0_r;
        entry.d2        = data_byte;
        phase_nxt       = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_SKIPLEN: begin
        acc_nxt = acc_push;
        if (!data_byte[7]) begin
          skip_nxt  = acc_push;
          acc_nxt   = '0;
          phase_nxt = (acc_push != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) phase_nxt = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_METATYPE: begin
        mtype_nxt = data_byte;
        if (data_byte == mtep_pkg::MetaTempo) begin
          phase_nxt = mtep_pkg::PH_TEMPOLEN;
        end else if (data_byte == mtep_pkg::MetaEot) begin
          phase_nxt = mtep_pkg::PH_EOTLEN;
        end else begin
          acc_nxt   = '0;
          phase_nxt = mtep_pkg::PH_SKIPLEN;
        end
      end
      mtep_pkg::PH_TEMPOLEN: begin
        hd3_nxt   = data_byte;
        phase_nxt = mtep_pkg::PH_TEMPO1;
      end
      mtep_pkg::PH_TEMPO1: begin
        hd0_nxt   = data_byte;
        phase_nxt = mtep_pkg::PH_TEMPO2;
      end
      mtep_pkg::PH_TEMPO2: begin
        hd1_nxt   = data_byte;
        phase_nxt = mtep_pkg::PH_TEMPO3;
      end
      mtep_pkg::PH_TEMPO3: begin
        entry.evt_valid = 1'b1;
        entry.evt_kind  = mtep_pkg::KIND_TEMPO;
        entry.status    = mtep_pkg::MetaStatus;
        entry.meta_type = mtype_r;
        entry.meta_len  = hd3_r;
        entry.d1        = hd0_r;
        entry.d2        = hd1_r;
        entry.d3        = data_byte;
        run_nxt         = '0;
        phase_nxt       = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_EOTLEN: begin
        hd3_nxt         = data_byte;
        entry.evt_valid = 1'b1;
        entry.evt_kind  = mtep_pkg::KIND_EOT;
        entry.status    = mtep_pkg::MetaStatus;
        entry.meta_type = mtype_r;
        entry.meta_len  = data_byte;
        run_nxt         = '0;
        phase_nxt       = mtep_pkg::PH_DELTA;
      end
      default: phase_nxt = mtep_pkg::PH_DELTA;
    endcase

    entry.delta     = mtep_pkg::delta_field(held_delta_nxt);
    entry.total     = tick_nxt;
    entry.end_valid = end_of_data;
    entry.end_trunc = !(phase_nxt == mtep_pkg::PH_DELTA && acc_nxt == '0);
    push            = accept && (entry.evt_valid || end_of_data);

    if (end_of_data) begin
      phase_nxt      = mtep_pkg::PH_DELTA;
      acc_nxt        = '0;
      held_delta_nxt = '0;
      tick_nxt       = '0;
      run_nxt        = '0;
      cur_nxt        = '0;
      mtype_nxt      = '0;
      hd0_nxt        = '0;
      hd1_nxt        = '0;
      hd3_nxt        = '0;
      skip_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mtep_pkg::PH_DELTA;
      acc_r        <= '0;
      held_delta_r <= '0;
      tick_r       <= '0;
      run_r        <= '0;
      cur_r        <= '0;
      mtype_r      <= '0;
      hd0_r        <= '0;
      hd1_r        <= '0;
      hd3_r        <= '0;
      skip_r       <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      held_delta_r <= held_delta_nxt;
      tick_r       <= tick_nxt;
      run_r        <= run_nxt;
      cur_r        <= cur_nxt;
      mtype_r      <= mtype_nxt;
      hd0_r        <= hd0_nxt;
      hd1_r        <= hd1_nxt;
      hd3_r        <= hd3_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// MIDI track event parser queue
// Small register queue of parsed entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mtep_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic                   full,
  output mtep_pkg::entry_t       head
);

  localparam int PW = mtep_pkg::QueuePtrW;
  localparam int CW = mtep_pkg::QueueCntW;

  mtep_pkg::entry_t slot_r [mtep_pkg::QueueDepth];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    not_empty = (cnt_r != '0);
    full      = (cnt_r == CW'(mtep_pkg::QueueDepth));
    head      = slot_r[rd_r];
    wr_nxt    = push ? PW'(wr_r + PW'(1)) : wr_r;
    rd_nxt    = pop  ? PW'(rd_r + PW'(1)) : rd_r;
    cnt_nxt   = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_entry;
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Expands queue entries into result items and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire mtep_pkg::entry_t  q_head,
  output logic                   q_pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output mtep_pkg::result_t      out_res
);

  logic               valid_r, valid_nxt;
  mtep_pkg::result_t  res_r, res_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_trunc_r, pend_trunc_nxt;
  logic [31:0]        pend_total_r, pend_total_nxt;
  logic               slot_free;
  mtep_pkg::result_t  end_res;
  mtep_pkg::result_t  evt_res;

  always_comb begin
    slot_free      = !valid_r || !out_stall;
    valid_nxt      = valid_r && out_stall;
    res_nxt        = res_r;
    pend_nxt       = pend_r;
    pend_trunc_nxt = pend_trunc_r;
    pend_total_nxt = pend_total_r;
    q_pop          = 1'b0;

    end_res       = '0;
    end_res.kind  = pend_trunc_r ? mtep_pkg::KIND_TRUNC : mtep_pkg::KIND_END;
    end_res.total = pend_total_r;
    end_res.last  = 1'b1;

    evt_res           = '0;
    evt_res.kind      = q_head.evt_kind;
    evt_res.delta     = q_head.delta;
    evt_res.total     = q_head.total;
    evt_res.status    = q_head.status;
    evt_res.meta_type = q_head.meta_type;
    evt_res.meta_len  = q_head.meta_len;
    evt_res.d1        = q_head.d1;
    evt_res.d2        = q_head.d2;
    evt_res.d3        = q_head.d3;
    evt_res.last      = !q_head.end_valid;

    if (slot_free) begin
      priority if (pend_r) begin
        res_nxt   = end_res;
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else if (q_valid) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        if (q_head.evt_valid) begin
          res_nxt        = evt_res;
          pend_nxt       = q_head.end_valid;
          pend_trunc_nxt = q_head.end_trunc;
          pend_total_nxt = q_head.total;
        end else begin
          res_nxt       = '0;
          res_nxt.kind  = q_head.end_trunc ? mtep_pkg::KIND_TRUNC : mtep_pkg::KIND_END;
          res_nxt.total = q_head.total;
          res_nxt.last  = 1'b1;
        end
      end
    end

    out_valid = valid_r;
    out_res   = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    pend_trunc_r <= pend_trunc_nxt;
    pend_total_r <= pend_total_nxt;
  end

endmodule

`default_nettype wire
